/* rtl/core/pvt_pkg.sv */
package pvt_pkg;

  localparam int MAX_GROUPS = 8;
  localparam int IDX_W      = $clog2(MAX_GROUPS);
  localparam int CNT_W      = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ADD   = 2'd1,
    OP_RESP  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_FAILED  = 2'd0,
    PH_PREPARE = 2'd1,
    PH_ACCEPT  = 2'd2,
    PH_DECIDED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    V_NONE      = 2'd0,
    V_YES       = 2'd1,
    V_NO        = 2'd2,
    V_UNCERTAIN = 2'd3
  } verdict_t;

  localparam logic KIND_PROMISE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIND,
    ST_ADD,
    ST_UPDATE,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        msg_kind;
    logic [31:0] group_id;
    logic [63:0] slot_id;
    logic [63:0] ballot_id;
    logic [7:0]  group_size;
    logic        ack_no;
    logic        has_proposal;
    logic [63:0] proposal_ballot;
    logic        last_in_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  txn_phase;
    logic [1:0]  verdict;
    logic        ignored;
    logic        best_valid;
    logic [63:0] best_ballot;
  } out_item_t;

  typedef struct packed {
    logic     load;
    logic     clr_all;
    logic     scan_clr;
    logic     scan_inc;
    logic     find_step;
    logic     add_write;
    logic     resp_update;
    logic     set_ignored;
    logic     set_verdict;
    verdict_t verdict;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic phase_ok;
    logic scan_end;
    logic id_hit;
    logic chk_no;
    logic chk_unc;
  } status_t;

endpackage

/* rtl/core/paxos_proposer_vote_tally_top.sv */
// Channel  | Ports                   | Handshake
// input    | start, busy, in_item    | taken when start && !busy
// result   | out_valid, out_item     | one-cycle strobe, no backpressure
//
// Each item gives one result. Start, no-op and wrong-phase response items
// pass from EXEC straight to DONE and the result register; add group and response
// items walk the group table one entry per cycle for a lookup, and the last
// response of a message walks it once more for the quorum check.
// Synchronous active-low reset clears counts, phase and best ballot.
// A new item may be started in the cycle its predecessor's result shows.
module paxos_proposer_vote_tally_top import pvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t    cmd;
  status_t sts;

  pvt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pvt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* rtl/core/pvt_ctrl.sv */
module pvt_ctrl import pvt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.verdict = V_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.op)
          OP_START: begin
            cmd.clr_all = 1'b1;
            state_nxt   = ST_DONE;
          end
          OP_ADD: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_FIND;
          end
          OP_RESP: begin
            if (!sts.phase_ok) begin
              cmd.set_ignored = 1'b1;
              state_nxt       = ST_DONE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = ST_FIND;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.scan_end || sts.id_hit) begin
          state_nxt = (sts.op == OP_ADD) ? ST_ADD : ST_UPDATE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_ADD: begin
        cmd.add_write = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_UPDATE: begin
        cmd.resp_update = 1'b1;
        if (sts.last) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_CHECK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHECK: begin
        // first failing group decides; an empty walk means all groups agree
        if (sts.scan_end) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = V_YES;
          state_nxt       = ST_DONE;
        end else if (sts.chk_no) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = V_NO;
          state_nxt       = ST_DONE;
        end else if (sts.chk_unc) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = V_UNCERTAIN;
          state_nxt       = ST_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/pvt_dp.sv */
module pvt_dp import pvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   sts,
  output logic      out_valid,
  output out_item_t out_item
);

  in_item_t item_r;

  logic [31:0] grp_id_r     [MAX_GROUPS];
  logic [63:0] grp_slot_r   [MAX_GROUPS];
  logic [63:0] grp_ballot_r [MAX_GROUPS];
  logic [7:0]  grp_size_r   [MAX_GROUPS];
  logic [7:0]  p_yes_r      [MAX_GROUPS];
  logic [7:0]  p_no_r       [MAX_GROUPS];
  logic [7:0]  a_yes_r      [MAX_GROUPS];
  logic [7:0]  a_no_r       [MAX_GROUPS];
  logic        gbest_v_r    [MAX_GROUPS];
  logic [63:0] gbest_r      [MAX_GROUPS];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_r;
  logic [IDX_W-1:0] idx_r;
  logic             found_r;
  phase_t           phase_r;
  verdict_t         verdict_r;
  logic             ignored_r;
  logic             tbest_v_r;
  logic [63:0]      tbest_r;

  logic [IDX_W-1:0] sidx;
  logic [IDX_W-1:0] add_idx;
  logic             add_ok;
  logic             match;
  logic             take_best;
  logic [7:0]       quorum;
  logic [7:0]       yes_cnt;
  logic [7:0]       no_cnt;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  assign sidx    = scan_r[IDX_W-1:0];
  assign add_idx = found_r ? idx_r : count_r[IDX_W-1:0];
  assign add_ok  = found_r || (count_r != CNT_W'(MAX_GROUPS));
  assign match   = found_r && (grp_slot_r[idx_r] == item_r.slot_id)
                   && (grp_ballot_r[idx_r] == item_r.ballot_id);
  assign take_best = match && item_r.has_proposal
                     && (!gbest_v_r[idx_r] || (gbest_r[idx_r] < item_r.proposal_ballot));

  assign quorum  = {1'b0, grp_size_r[sidx][7:1]} + 8'd1;
  assign yes_cnt = (phase_r == PH_PREPARE) ? p_yes_r[sidx] : a_yes_r[sidx];
  assign no_cnt  = (phase_r == PH_PREPARE) ? p_no_r[sidx]  : a_no_r[sidx];

  always_comb begin
    sts.op       = op_t'(item_r.operation);
    sts.last     = item_r.last_in_message;
    sts.phase_ok = (phase_r == ((item_r.msg_kind == KIND_PROMISE) ? PH_PREPARE : PH_ACCEPT));
    sts.scan_end = (scan_r >= count_r);
    sts.id_hit   = (grp_id_r[sidx] == item_r.group_id);
    sts.chk_no   = (no_cnt >= quorum);
    sts.chk_unc  = (yes_cnt < quorum);
  end

  // group table payload, held item, index and result registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.find_step) begin
      idx_r <= sidx;
    end
    if (cmd.add_write && add_ok) begin
      grp_id_r[add_idx]     <= item_r.group_id;
      grp_slot_r[add_idx]   <= item_r.slot_id;
      grp_ballot_r[add_idx] <= item_r.ballot_id;
      grp_size_r[add_idx]   <= item_r.group_size;
    end
    if (cmd.emit) begin
      out_item.txn_phase   <= phase_r;
      out_item.verdict     <= verdict_r;
      out_item.ignored     <= ignored_r;
      out_item.best_valid  <= tbest_v_r;
      out_item.best_ballot <= tbest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_GROUPS; i++) begin
        p_yes_r[i]   <= '0;
        p_no_r[i]    <= '0;
        a_yes_r[i]   <= '0;
        a_no_r[i]    <= '0;
        gbest_v_r[i] <= 1'b0;
        gbest_r[i]   <= '0;
      end
      count_r   <= '0;
      scan_r    <= '0;
      found_r   <= 1'b0;
      phase_r   <= PH_PREPARE;
      verdict_r <= V_NONE;
      ignored_r <= 1'b0;
      tbest_v_r <= 1'b0;
      tbest_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.load) begin
        found_r   <= 1'b0;
        verdict_r <= V_NONE;
        ignored_r <= 1'b0;
      end
      if (cmd.scan_clr) begin
        scan_r <= '0;
      end else if (cmd.scan_inc) begin
        scan_r <= scan_r + CNT_W'(1);
      end
      if (cmd.find_step && !sts.scan_end && sts.id_hit) begin
        found_r <= 1'b1;
      end
      if (cmd.clr_all) begin
        for (int i = 0; i < MAX_GROUPS; i++) begin
          p_yes_r[i]   <= '0;
          p_no_r[i]    <= '0;
          a_yes_r[i]   <= '0;
          a_no_r[i]    <= '0;
          gbest_v_r[i] <= 1'b0;
          gbest_r[i]   <= '0;
        end
        count_r   <= '0;
        phase_r   <= PH_PREPARE;
        tbest_v_r <= 1'b0;
        tbest_r   <= '0;
      end
      if (cmd.add_write && add_ok) begin
        p_yes_r[add_idx]   <= '0;
        p_no_r[add_idx]    <= '0;
        a_yes_r[add_idx]   <= '0;
        a_no_r[add_idx]    <= '0;
        gbest_v_r[add_idx] <= 1'b0;
        gbest_r[add_idx]   <= '0;
        if (!found_r) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.set_ignored) begin
        ignored_r <= 1'b1;
      end
      if (cmd.resp_update) begin
        ignored_r <= !match;
        if (match) begin
          if (phase_r == PH_PREPARE) begin
            if (item_r.ack_no) p_no_r[idx_r]  <= sat_inc(p_no_r[idx_r]);
            else               p_yes_r[idx_r] <= sat_inc(p_yes_r[idx_r]);
          end else begin
            if (item_r.ack_no) a_no_r[idx_r]  <= sat_inc(a_no_r[idx_r]);
            else               a_yes_r[idx_r] <= sat_inc(a_yes_r[idx_r]);
          end
        end
        if (take_best) begin
          gbest_v_r[idx_r] <= 1'b1;
          gbest_r[idx_r]   <= item_r.proposal_ballot;
          if (!tbest_v_r || (item_r.proposal_ballot > tbest_r)) begin
            tbest_v_r <= 1'b1;
            tbest_r   <= item_r.proposal_ballot;
          end
        end
      end
      if (cmd.set_verdict) begin
        verdict_r <= cmd.verdict;
        if (cmd.verdict == V_YES) begin
          phase_r <= (phase_r == PH_PREPARE) ? PH_ACCEPT : PH_DECIDED;
        end else if (cmd.verdict == V_NO) begin
          phase_r <= PH_FAILED;
        end
      end
    end
  end

endmodule

/* rtl/core/pvt_checker.sv */
module pvt_checker import pvt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after item taken");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_no_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.verdict == V_NO) |-> (out_item.txn_phase == PH_FAILED))
    else $error("majority no without failed phase");

  a_yes_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.verdict == V_YES)
      |-> (out_item.txn_phase == PH_ACCEPT || out_item.txn_phase == PH_DECIDED))
    else $error("majority yes without phase advance");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid)) else $error("not idle after reset");

endmodule

bind paxos_proposer_vote_tally_top pvt_checker u_pvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

/* tb/sv/tb_top.sv */
module tb_top import pvt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 1200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  paxos_proposer_vote_tally_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #1 clk = ~clk;

  // shadow of the tally state
  logic [31:0] t_id [MAX_GROUPS];
  logic [63:0] t_slot [MAX_GROUPS];
  logic [63:0] t_ballot [MAX_GROUPS];
  logic [7:0]  t_size [MAX_GROUPS];
  logic [7:0]  p_yes [MAX_GROUPS], p_no [MAX_GROUPS];
  logic [7:0]  a_yes [MAX_GROUPS], a_no [MAX_GROUPS];
  logic        g_bval [MAX_GROUPS];
  logic [63:0] g_bbal [MAX_GROUPS];
  int          n_groups;
  phase_t      cur_phase;
  logic        best_ok;
  logic [63:0] best_bal;

  out_item_t expected_results[$];
  int        errors = 0;
  int        n_taken = 0, n_seen = 0, idle_cycles = 0;
  int        n_decided = 0, n_failed = 0;

  function automatic logic [7:0] bump(logic [7:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

  function automatic void wipe_counts(int i);
    p_yes[i] = '0; p_no[i] = '0; a_yes[i] = '0; a_no[i] = '0;
    g_bval[i] = 1'b0; g_bbal[i] = '0;
  endfunction

  function automatic void clear_tally();
    for (int i = 0; i < MAX_GROUPS; i++) wipe_counts(i);
    n_groups = 0;
    cur_phase = PH_PREPARE;
    best_ok = 1'b0;
    best_bal = '0;
  endfunction

  function automatic int lookup(logic [31:0] id);
    for (int i = 0; i < n_groups; i++) if (t_id[i] == id) return i;
    return -1;
  endfunction

  function automatic verdict_t tally_quorum(phase_t ph);
    logic [8:0] q;
    logic [7:0] y, n;
    for (int i = 0; i < n_groups; i++) begin
      q = {1'b0, t_size[i] >> 1} + 9'd1;
      y = (ph == PH_PREPARE) ? p_yes[i] : a_yes[i];
      n = (ph == PH_PREPARE) ? p_no[i] : a_no[i];
      if ({1'b0, n} >= q) return V_NO;
      if ({1'b0, y} < q) return V_UNCERTAIN;
    end
    return V_YES;
  endfunction

  function automatic out_item_t tally_step(in_item_t it);
    out_item_t r;
    verdict_t v;
    phase_t want;
    int e;
    v = V_NONE;
    r = '0;
    case (op_t'(it.operation))
      OP_START: clear_tally();
      OP_ADD: begin
        e = lookup(it.group_id);
        if (e < 0 && n_groups < MAX_GROUPS) begin
          e = n_groups;
          n_groups++;
        end
        if (e >= 0) begin
          t_id[e] = it.group_id; t_slot[e] = it.slot_id;
          t_ballot[e] = it.ballot_id; t_size[e] = it.group_size;
          wipe_counts(e);
        end
      end
      OP_RESP: begin
        want = (it.msg_kind == KIND_PROMISE) ? PH_PREPARE : PH_ACCEPT;
        if (cur_phase != want) begin
          r.ignored = 1'b1;
        end else begin
          e = lookup(it.group_id);
          if (e < 0 || t_slot[e] != it.slot_id || t_ballot[e] != it.ballot_id) begin
            r.ignored = 1'b1;
          end else begin
            if (want == PH_PREPARE) begin
              if (it.ack_no) p_no[e] = bump(p_no[e]);
              else p_yes[e] = bump(p_yes[e]);
            end else begin
              if (it.ack_no) a_no[e] = bump(a_no[e]);
              else a_yes[e] = bump(a_yes[e]);
            end
            if (it.has_proposal && (!g_bval[e] || g_bbal[e] < it.proposal_ballot)) begin
              g_bval[e] = 1'b1;
              g_bbal[e] = it.proposal_ballot;
              if (!best_ok || it.proposal_ballot > best_bal) begin
                best_ok = 1'b1;
                best_bal = it.proposal_ballot;
              end
            end
          end
          if (it.last_in_message) begin
            v = tally_quorum(want);
            if (v == V_YES) cur_phase = (want == PH_PREPARE) ? PH_ACCEPT : PH_DECIDED;
            else if (v == V_NO) cur_phase = PH_FAILED;
          end
        end
      end
      default: ;
    endcase
    r.txn_phase = cur_phase;
    r.verdict = v;
    r.best_valid = best_ok;
    r.best_ballot = best_ok ? best_bal : '0;
    return r;
  endfunction

  // check results
  always @(posedge clk) begin
    out_item_t x;
    if (rst_n && out_valid) begin
      n_seen <= n_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        errors++;
      end else begin
        x = expected_results.pop_front();
        if (out_item.txn_phase === PH_DECIDED && x.txn_phase == PH_DECIDED) n_decided++;
        if (out_item.txn_phase !== x.txn_phase) begin
          $error("txn_phase exp %0d got %0d", x.txn_phase, out_item.txn_phase); errors++;
        end
        if (out_item.verdict !== x.verdict) begin
          $error("verdict exp %0d got %0d", x.verdict, out_item.verdict); errors++;
        end
        if (out_item.ignored !== x.ignored) begin
          $error("ignored exp %0d got %0d", x.ignored, out_item.ignored); errors++;
        end
        if (out_item.best_valid !== x.best_valid) begin
          $error("best_valid exp %0d got %0d", x.best_valid, out_item.best_valid); errors++;
        end
        if (out_item.best_ballot !== x.best_ballot) begin
          $error("best_ballot exp %0h got %0h", x.best_ballot, out_item.best_ballot); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout with %0d results pending", expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  typedef struct {
    in_item_t  it;
    logic      known;
    out_item_t res;
  } stim_row_t;

  stim_row_t dir_rows[$];
  logic      no_gaps = 1'b0;

  // drive one item; checked against a typed value when given
  // start stays high after the taking edge; busy blocks a second take
  task automatic send_item(in_item_t it, logic known, out_item_t typed);
    out_item_t p;
    while (!no_gaps && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = tally_step(it);
    if (known && p !== typed) begin
      $error("directed row %0d: table %p predictor %p", n_taken, typed, p);
      errors++;
    end
    expected_results.push_back(p);
    n_taken++;
  endtask

  function automatic in_item_t mk(op_t op, logic k, logic [31:0] g, logic [63:0] s,
                                  logic [63:0] b, logic [7:0] sz, logic no, logic hp,
                                  logic [63:0] pb, logic last);
    in_item_t it;
    it.operation = op; it.msg_kind = k; it.group_id = g; it.slot_id = s;
    it.ballot_id = b; it.group_size = sz; it.ack_no = no; it.has_proposal = hp;
    it.proposal_ballot = pb; it.last_in_message = last;
    return it;
  endfunction

  function automatic out_item_t res(phase_t ph, verdict_t v, logic ig, logic bv,
                                    logic [63:0] bb);
    out_item_t r;
    r.txn_phase = ph; r.verdict = v; r.ignored = ig; r.best_valid = bv; r.best_ballot = bb;
    return r;
  endfunction

  function automatic void row(in_item_t it, logic known, out_item_t r);
    stim_row_t s;
    s.it = it; s.known = known; s.res = r;
    dir_rows.push_back(s);
  endfunction

  localparam logic [63:0] ONES = '1;

  function automatic void build_directed();
    row(mk(OP_NOP, 1, '1, ONES, ONES, 8'hff, 1, 1, ONES, 1), 1,
        res(PH_PREPARE, V_NONE, 0, 0, 0));
    // empty table: majority yes
    row(mk(OP_RESP, 0, 0, 0, 0, 1, 0, 0, 0, 1), 1, res(PH_ACCEPT, V_YES, 1, 0, 0));
    // wrong phase, no check
    row(mk(OP_RESP, 0, 0, 0, 0, 1, 0, 0, 0, 1), 1, res(PH_ACCEPT, V_NONE, 1, 0, 0));
    row(mk(OP_START, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1, res(PH_PREPARE, V_NONE, 0, 0, 0));
    row(mk(OP_ADD, 0, '1, ONES, ONES, 8'd255, 0, 0, 0, 0), 1,
        res(PH_PREPARE, V_NONE, 0, 0, 0));
    row(mk(OP_ADD, 0, 0, 0, 0, 8'd1, 0, 0, 0, 0), 0, '0);
    row(mk(OP_ADD, 0, 0, 5, 6, 8'd2, 0, 0, 0, 0), 0, '0);
    // stale round
    row(mk(OP_RESP, 0, 0, 0, 0, 1, 0, 1, 7, 0), 0, '0);
    row(mk(OP_RESP, 0, 0, 5, 6, 1, 0, 1, ONES, 0), 0, '0);
    row(mk(OP_RESP, 0, 0, 5, 6, 1, 0, 1, 1, 1), 0, '0);
    row(mk(OP_RESP, 0, 32'h1234, 5, 6, 1, 1, 0, 0, 1), 0, '0);
    for (int i = 0; i < 7; i++)
      row(mk(OP_ADD, 0, 32'h100 + i, i, i, 8'd1, 0, 0, 0, 0), 0, '0);
    for (int i = 0; i < 8; i++)
      row(mk(OP_RESP, 0, 32'h100 + i, i, i, 1, i[0], 0, 0, i == 7), 0, '0);
    row(mk(OP_START, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1, res(PH_PREPARE, V_NONE, 0, 0, 0));
  endfunction

  // mostly well-formed rounds with random content; some noise
  task automatic random_round();
    int ng, sz, msgs;
    logic [31:0] ids [MAX_GROUPS];
    logic [63:0] sl [MAX_GROUPS], bl [MAX_GROUPS];
    in_item_t it;
    out_item_t dc;
    dc = '0;
    send_item(mk(OP_START, $urandom, $urandom, {$urandom, $urandom}, 0, 1, 0, 0, 0, 0), 0, dc);
    ng = $urandom_range(0, 9);
    for (int g = 0; g < ng; g++) begin
      ids[g % MAX_GROUPS] = ($urandom_range(3) == 0) ? {$urandom} : 32'h10 + g % MAX_GROUPS;
      sl[g % MAX_GROUPS] = {$urandom, $urandom};
      bl[g % MAX_GROUPS] = ($urandom_range(1)) ? {$urandom, $urandom} : $urandom_range(3);
      sz = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 5);
      send_item(mk(OP_ADD, $urandom, ids[g % MAX_GROUPS], sl[g % MAX_GROUPS],
                   bl[g % MAX_GROUPS], sz[7:0], $urandom, $urandom, {$urandom, $urandom},
                   $urandom), 0, dc);
    end
    if (ng > MAX_GROUPS) ng = MAX_GROUPS;
    msgs = $urandom_range(1, 4);
    for (int m = 0; m < msgs; m++) begin
      for (int k = 0; k < ng * 3 + 1; k++) begin
        int g;
        g = (ng == 0) ? 0 : $urandom_range(ng - 1);
        it = mk(OP_RESP, (cur_phase == PH_ACCEPT), ids[g], sl[g], bl[g], $urandom,
                ($urandom_range(5) == 0), $urandom, {$urandom, $urandom},
                (k == ng * 3));
        if (ng == 0 || $urandom_range(9) == 0) begin
          it.group_id = $urandom; it.slot_id = {$urandom, $urandom};
          it.ballot_id = {$urandom, $urandom}; it.msg_kind = 1'($urandom);
          it.operation = 2'($urandom_range(3));
        end
        send_item(it, 0, dc);
      end
    end
  endtask

  initial begin
    clear_tally();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    build_directed();
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].res);
    while (n_taken < N_RANDOM) begin
      no_gaps = (n_taken > 500 && n_taken < 650);
      random_round();
    end
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * MAX_GROUPS + 10) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d decided results seen",
             n_taken, n_seen, n_decided);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
